FILE: hw/rtl/frequency_ordered_list_core_macros.svh
// ----------------------------------------------------------------------------
// Frequency ordered list - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_CORE_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check on every clock edge outside reset
`define FOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check on every clock edge, reset included
`define FOL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FOL_ASSERT(lbl, prop, msg)
`define FOL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/fol_pkg.sv
// ----------------------------------------------------------------------------
// Frequency ordered list - package
// Sizes, command and status codes, item types and cell control.
// ----------------------------------------------------------------------------
package fol_pkg;

  // table geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);

  // field widths
  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int EIDX_W = 4;
  localparam int ST_W = 2;
  localparam int POS_W = 4;
  localparam int CNT_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic signed [KEY_W-1:0] key_value;
    logic [EIDX_W-1:0] entry_index;
  } req_item_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [POS_W-1:0] position;
    logic signed [KEY_W-1:0] entry_key;
    logic [CNT_W-1:0] entry_count;
  } res_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic locate_go;
    logic append_go;
    logic [KEY_W-1:0] probe_key;
    logic [KEY_W-1:0] new_key;
    logic [CNT_W-1:0] new_cnt;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/frequency_ordered_list_core.sv
// ----------------------------------------------------------------------------
// Frequency ordered list - top level
// Self-organizing key table ordered by access count, built as a row of cells.
// ----------------------------------------------------------------------------
// Each item is accepted while idle and finished in the work state. At the
// accept edge every cell compares its key with the request at once and the
// first-match chain along the row picks the hit; the following cycle
// increments its count, the cells find the move span by comparing counts,
// and the whole row shifts together. busy is high in the work state only. The
// result sits on the result ports, flagged by done, which rises as busy falls;
// the receiver cannot hold it off, and a new item may be started while done
// is high. No clearing pass follows reset: the table is empty at once.
// ----------------------------------------------------------------------------
`include "frequency_ordered_list_core_macros.svh"

module frequency_ordered_list_core
  import fol_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_item_t request,
  output logic      busy,
  output logic      done,
  output res_item_t result
);

  state_t state, state_next;
  logic accept;
  logic commit;

  logic [LEN_W-1:0] length;

  // latched item and accept-cycle search results
  logic [CMD_W-1:0] op_cmd;
  logic [KEY_W-1:0] op_key;
  logic [IDX_W-1:0] op_idx;
  logic [DEPTH-1:0] hit;
  logic             found;
  logic [CNT_W-1:0] hit_cnt;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_ok;

  // cell row wiring
  logic [KEY_W-1:0] key_c [DEPTH+1];
  logic [CNT_W-1:0] cnt_c [DEPTH+1];
  logic [DEPTH:0]   seen_c;
  logic [DEPTH+1:0] in_c;
  logic [DEPTH-1:0] first_v;
  cell_ctl_t        ctl;

  logic             full;
  logic             locate_go;
  logic             append_go;
  logic [CNT_W-1:0] cnt_new;
  logic [IDX_W-1:0] dst;

  logic [KEY_W-1:0] sel_key;
  logic [CNT_W-1:0] sel_cnt;
  logic [CNT_W-1:0] first_cnt;
  res_item_t        result_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_WORK;
      S_WORK: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b0;
    commit = 1'b0;
    case (state)
      S_IDLE: busy = 1'b0;
      S_WORK: begin
        busy   = 1'b1;
        commit = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // chain ends
  assign key_c[0]      = '0;
  assign cnt_c[0]      = '0;
  assign seen_c[0]     = 1'b0;
  assign in_c[0]       = 1'b0;
  assign in_c[DEPTH+1] = 1'b0;

  assign full      = (length == LEN_W'(DEPTH));
  assign locate_go = commit && (op_cmd == CMD_LOCATE) && found;
  assign append_go = commit && (op_cmd == CMD_APPEND) && !full;
  assign cnt_new   = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;

  always_comb begin
    ctl.locate_go = locate_go;
    ctl.append_go = append_go;
    ctl.probe_key = request.key_value;
    ctl.new_key   = op_key;
    ctl.new_cnt   = cnt_new;
  end

  // row of cells; cell j sits at index j+1 of the chain arrays
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    fol_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (LEN_W'(j) < length),
      .tail     (LEN_W'(j) == length),
      .hit      (hit[j]),
      .seen_in  (seen_c[j]),
      .in_prev  (in_c[j]),
      .in_next  (in_c[j+2]),
      .prev_key (key_c[j]),
      .prev_cnt (cnt_c[j]),
      .seen_out (seen_c[j+1]),
      .first    (first_v[j]),
      .in_here  (in_c[j+1]),
      .key      (key_c[j+1]),
      .cnt      (cnt_c[j+1])
    );
  end

  // accept-cycle selection: read port and count at the hit
  always_comb begin
    sel_key   = '0;
    sel_cnt   = '0;
    first_cnt = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (IDX_W'(j) == IDX_W'(request.entry_index)) begin
        sel_key = key_c[j+1];
        sel_cnt = cnt_c[j+1];
      end
      if (first_v[j]) first_cnt = first_cnt | cnt_c[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= request.cmd;
      op_key  <= request.key_value;
      op_idx  <= IDX_W'(request.entry_index);
      hit     <= first_v;
      found   <= seen_c[DEPTH];
      hit_cnt <= first_cnt;
      rd_key  <= sel_key;
      rd_cnt  <= sel_cnt;
      rd_ok   <= (LEN_W'(request.entry_index) < length);
    end
  end

  // head of the moving span is the final position
  always_comb begin
    dst = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (in_c[j+1] && !in_c[j]) dst = dst | IDX_W'(j);
    end
  end

  // result assembly
  always_comb begin
    result_next = '0;
    result_next.status = ST_OK;
    case (op_cmd)
      CMD_APPEND: begin
        if (full) begin
          result_next.status = ST_FULL;
        end else begin
          result_next.position  = POS_W'(length[IDX_W-1:0]);
          result_next.entry_key = op_key;
        end
      end
      CMD_LOCATE: begin
        if (found) begin
          result_next.position    = POS_W'(dst);
          result_next.entry_key   = op_key;
          result_next.entry_count = cnt_new;
        end else begin
          result_next.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (rd_ok) begin
          result_next.position    = POS_W'(op_idx);
          result_next.entry_key   = rd_key;
          result_next.entry_count = rd_cnt;
        end else begin
          result_next.status = ST_BAD_INDEX;
        end
      end
      default: result_next.status = ST_OK;
    endcase
  end

  // length and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      done <= commit;
      if (append_go) length <= length + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) result <= result_next;
  end

  // checks
  `FOL_ASSERT(a_done_after_work, done |-> $past(commit), "result without work cycle")
  `FOL_ASSERT(a_len_bound, length <= LEN_W'(DEPTH), "table length beyond depth")
  `FOL_ASSERT(a_hit_onehot, commit |-> $onehot0(hit), "more than one hit cell")
  `FOL_ASSERT(a_append_grows, append_go |=> length == LEN_W'($past(length) + 1'b1),
    "append did not grow table")
  `FOL_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "not idle after reset")

endmodule

FILE: hw/rtl/fol_cell.sv
// ----------------------------------------------------------------------------
// Frequency ordered list - table cell
// Holds one entry, compares it against the probe key and takes part in the
// first-match and move-forward chains with its neighbors.
// ----------------------------------------------------------------------------
module fol_cell
  import fol_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             valid,     // entry lies below the table length
  input  logic             tail,      // first free slot
  input  logic             hit,       // this entry was located
  input  logic             seen_in,   // a lower cell already matched
  input  logic             in_prev,   // lower neighbor is in the moving span
  input  logic             in_next,   // upper neighbor is in the moving span
  input  logic [KEY_W-1:0] prev_key,
  input  logic [CNT_W-1:0] prev_cnt,
  output logic             seen_out,
  output logic             first,
  output logic             in_here,
  output logic [KEY_W-1:0] key,
  output logic [CNT_W-1:0] cnt
);

  logic match;
  logic le;

  // first-match chain runs from the head
  assign match    = valid && (key == ctl.probe_key);
  assign first    = match && !seen_in;
  assign seen_out = seen_in || match;

  // moving span grows from the hit cell toward the head
  assign le      = (cnt <= ctl.new_cnt);
  assign in_here = hit || (in_next && le);

  // head of span takes the located entry, the rest shift up by one
  always_ff @(posedge clk) begin
    if (ctl.locate_go && in_here) begin
      if (in_prev) begin
        key <= prev_key;
        cnt <= prev_cnt;
      end else begin
        key <= ctl.new_key;
        cnt <= ctl.new_cnt;
      end
    end else if (ctl.append_go && tail) begin
      key <= ctl.new_key;
      cnt <= '0;
    end
  end

endmodule
